// ===== hw/rtl/gradient_nms_edge_threshold_assert.svh =====
// Assertion macros shared by the edge-threshold block.
`ifndef GRADIENT_NMS_EDGE_THRESHOLD_ASSERT_SVH
`define GRADIENT_NMS_EDGE_THRESHOLD_ASSERT_SVH
// Consequence must hold in the same cycle as the antecedent.
`define GNET_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Consequence must hold in the cycle after the antecedent.
`define GNET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hw/rtl/gnet_pkg.sv =====
// Shared types and constants of the edge-threshold block.
package gnet_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_THRESHOLD_SQ  = 3'd2;
  localparam logic [2:0] REG_WINDOW_TAN    = 3'd3;
  localparam logic [2:0] REG_DIAG_LOW_TAN  = 3'd4;
  localparam logic [2:0] REG_DIAG_HIGH_TAN = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  // wide enough to clamp any frame dimension up to 4096
  localparam int DIM_CALC_W = 13;

  // direction classes
  localparam logic [1:0] CLS_DOWN   = 2'd0;
  localparam logic [1:0] CLS_ACROSS = 2'd1;
  localparam logic [1:0] CLS_MAIN   = 2'd2;
  localparam logic [1:0] CLS_ANTI   = 2'd3;

  // input kind codes
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // controller -> datapath commands, one step each
  typedef struct packed {
    logic capture;   // latch input beat
    logic l_pos;     // position, abs values, line reads
    logic l_mul;     // products, store address
    logic l_cls;     // class, window shift, line writes, border write
    logic l_sup;     // suppression write, max, advance position
    logic r_addr;    // readout address, store read, threshold product
    logic r_out;     // compare, load output register
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic kind;      // kind of latched beat
    logic out_busy;  // output register holds a beat not taken this cycle
  } status_t;

endpackage

// ===== hw/rtl/gnet_ctrl.sv =====
// Sequencer for load and readout beats.
module gnet_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  gnet_pkg::status_t status,
  output gnet_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LPOS = 3'd1;
  localparam logic [2:0] S_LMUL = 3'd2;
  localparam logic [2:0] S_LCLS = 3'd3;
  localparam logic [2:0] S_LSUP = 3'd4;
  localparam logic [2:0] S_RADR = 3'd5;
  localparam logic [2:0] S_ROUT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       pick;

  // capture happens on the accept edge; kind is known in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pick  <= 1'b0;
    end else begin
      state <= state_next;
      pick  <= in_valid && (state == S_IDLE);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_LPOS;
      S_LPOS: begin
        if (status.kind == gnet_pkg::KIND_READ) state_next = S_RADR;
        else state_next = S_LMUL;
      end
      S_LMUL: state_next = S_LCLS;
      S_LCLS: state_next = S_LSUP;
      S_LSUP: state_next = S_IDLE;
      S_RADR: state_next = S_ROUT;
      S_ROUT: if (!status.out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = (state == S_IDLE) && in_valid;
  assign cmd.l_pos   = (state == S_LPOS) && (status.kind == gnet_pkg::KIND_LOAD);
  assign cmd.l_mul   = (state == S_LMUL);
  assign cmd.l_cls   = (state == S_LCLS);
  assign cmd.l_sup   = (state == S_LSUP);
  assign cmd.r_addr  = (state == S_RADR);
  assign cmd.r_out   = (state == S_ROUT) && !status.out_busy;

`include "gradient_nms_edge_threshold_assert.svh"
  `GNET_ASSERT_NOW(a_one_step, 1'b1, $onehot0({cmd.l_pos, cmd.l_mul, cmd.l_cls, cmd.l_sup, cmd.r_addr, cmd.r_out}), "more than one datapath step")
  `GNET_ASSERT_NEXT(a_load_chain, cmd.l_pos, cmd.l_mul, "load steps out of order")
  `GNET_ASSERT_NEXT(a_hold_result, (state == S_ROUT) && status.out_busy, state == S_ROUT, "result dropped while output busy")
  `GNET_ASSERT_NEXT(a_capture_pick, cmd.capture, pick && (state == S_LPOS), "accepted beat not picked up")

endmodule

// ===== hw/rtl/gnet_datapath.sv =====
// Datapath: config registers, line and frame stores, classifier, suppression, readout.
module gnet_datapath #(
  parameter int MAX_WIDTH  = 640,
  parameter int MAX_HEIGHT = 480,
  parameter int GRAD_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gnet_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gnet_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_kind,
  input  logic [GRAD_BITS-1:0]                in_grad_down,
  input  logic [GRAD_BITS-1:0]                in_grad_across,
  input  gnet_pkg::cmd_t                      cmd,
  output gnet_pkg::status_t                   status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_edge_bit,
  output logic                                out_last_pixel
);

  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int RW   = $clog2(MAX_HEIGHT + 1);
  localparam int CIW  = $clog2(MAX_WIDTH);
  localparam int LIW  = $clog2(2 * MAX_WIDTH);
  localparam int TW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int G    = GRAD_BITS;
  localparam int MW   = 2 * GRAD_BITS + 1;
  localparam int PW   = 24 + GRAD_BITS + 1;
  localparam int SW   = 16 + MW;
  localparam int DW   = gnet_pkg::DIM_CALC_W;

  // configuration registers
  logic [9:0]  frame_width;
  logic [8:0]  frame_height;
  logic [15:0] threshold_sq;
  logic [16:0] window_tan;
  logic [23:0] diag_low_tan;
  logic [23:0] diag_high_tan;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= 10'd640;
      frame_height  <= 9'd480;
      threshold_sq  <= 16'd1475;
      window_tan    <= 17'd27146;
      diag_low_tan  <= 24'd27146;
      diag_high_tan <= 24'd158217;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gnet_pkg::REG_FRAME_WIDTH:   frame_width   <= cfg_wdata[9:0];
        gnet_pkg::REG_FRAME_HEIGHT:  frame_height  <= cfg_wdata[8:0];
        gnet_pkg::REG_THRESHOLD_SQ:  threshold_sq  <= cfg_wdata[15:0];
        gnet_pkg::REG_WINDOW_TAN:    window_tan    <= cfg_wdata[16:0];
        gnet_pkg::REG_DIAG_LOW_TAN:  diag_low_tan  <= cfg_wdata[23:0];
        gnet_pkg::REG_DIAG_HIGH_TAN: diag_high_tan <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // clamped frame size
  logic [DW-1:0] w_calc, h_calc;
  logic [CW-1:0] w_dim;
  logic [RW-1:0] h_dim;
  always_comb begin
    w_calc = DW'(frame_width);
    h_calc = DW'(frame_height);
    if (w_calc < DW'(3)) w_calc = DW'(3);
    else if (w_calc > DW'(MAX_WIDTH)) w_calc = DW'(MAX_WIDTH);
    if (h_calc < DW'(3)) h_calc = DW'(3);
    else if (h_calc > DW'(MAX_HEIGHT)) h_calc = DW'(MAX_HEIGHT);
  end
  assign w_dim = CW'(w_calc);
  assign h_dim = RW'(h_calc);

  // pixels per frame, registered off the config path
  logic [TW-1:0] total_q;
  always_ff @(posedge clk) total_q <= TW'(h_dim) * TW'(w_dim);

  // latched input beat
  logic         kind_q;
  logic [G-1:0] gd_q, ga_q;
  always_ff @(posedge clk) begin
    if (rst) kind_q <= gnet_pkg::KIND_LOAD;
    else if (cmd.capture) kind_q <= in_kind;
  end
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      gd_q <= in_grad_down;
      ga_q <= in_grad_across;
    end
  end

  // load position with wrap
  logic [CW-1:0] load_col, c_wr, c_q;
  logic [RW-1:0] load_row, r_inc, r_wr, r_q;
  always_comb begin
    c_wr  = load_col;
    r_inc = load_row;
    if (load_col >= w_dim) begin
      c_wr  = '0;
      r_inc = load_row + RW'(1);
    end
    r_wr = (r_inc >= h_dim) ? '0 : r_inc;
  end

  // line store indexes: up2 row is this row's slot, up1 the other
  logic [LIW-1:0] idx_up2, idx_up1, idx_wr;
  assign idx_up2 = (r_wr[0] ? LIW'(MAX_WIDTH) : LIW'(0)) + LIW'(c_wr);
  assign idx_up1 = (r_wr[0] ? LIW'(0) : LIW'(MAX_WIDTH)) + LIW'(c_wr);
  assign idx_wr  = (r_q[0] ? LIW'(MAX_WIDTH) : LIW'(0)) + LIW'(c_q);

  // absolute values
  logic         nd_q, na_q;
  logic [G-1:0] ad_q, aa_q;
  logic [MW-1:0] frame_max;
  logic [AW-1:0] read_addr;

  // products
  logic [2*G-1:0] sq_d, sq_a;
  logic [PW-1:0]  wt_d, wt_a, dl_d, dh_d;
  logic [TW-1:0]  addr_cur;

  // 3x3 magnitude window, rows top/mid/bottom, columns old..new
  logic [MW-1:0] win [3][3];
  logic [1:0]    held_class, cc_q, cls_rd;
  logic [MW-1:0] up2_rd, up1_rd;

  logic [MW-1:0] mag;
  logic [1:0]    cls;
  logic [PW-1:0] aa16, ad16;
  logic          border;

  assign mag  = MW'(sq_d) + MW'(sq_a);
  assign aa16 = PW'({aa_q, 16'b0});
  assign ad16 = PW'({ad_q, 16'b0});
  assign border = (r_q == '0) || (r_q == h_dim - RW'(1)) ||
                  (c_q == '0) || (c_q == w_dim - CW'(1));

  // direction class, tested in order
  always_comb begin
    priority if (ad_q == '0) cls = gnet_pkg::CLS_ACROSS;
    else if (aa16 <= wt_d) cls = gnet_pkg::CLS_DOWN;
    else if (ad16 <= wt_a) cls = gnet_pkg::CLS_ACROSS;
    else if ((nd_q == na_q) && (aa_q != '0) && (dl_d <= aa16) && (aa16 <= dh_d))
      cls = gnet_pkg::CLS_MAIN;
    else cls = gnet_pkg::CLS_ANTI;
  end

  // suppression against the two neighbors along the class
  logic [MW-1:0] nb_p, nb_q, sup;
  logic          sup_en;
  always_comb begin
    unique case (cc_q)
      gnet_pkg::CLS_DOWN:   begin nb_p = win[2][1]; nb_q = win[0][1]; end
      gnet_pkg::CLS_ACROSS: begin nb_p = win[1][2]; nb_q = win[1][0]; end
      gnet_pkg::CLS_MAIN:   begin nb_p = win[2][2]; nb_q = win[0][0]; end
      default:              begin nb_p = win[2][0]; nb_q = win[0][2]; end
    endcase
    sup = ((win[1][1] > nb_p) && (win[1][1] > nb_q)) ? win[1][1] : '0;
  end
  assign sup_en = (r_q >= RW'(2)) && (c_q >= CW'(2));

  // next load position
  logic [CW-1:0] c_inc;
  logic [RW-1:0] r_nxt;
  assign c_inc = c_q + CW'(1);
  assign r_nxt = (r_q + RW'(1) >= h_dim) ? '0 : r_q + RW'(1);

  // readout
  logic [TW-1:0] ra_ext, ra_sel;
  logic [AW-1:0] a_q;
  logic          last_q;
  logic [SW-1:0] thr_prod;
  logic [MW-1:0] frame_rd;
  assign ra_ext = TW'(read_addr);
  assign ra_sel = (ra_ext < total_q) ? ra_ext : '0;

  // position, products, window and readout registers
  always_ff @(posedge clk) begin
    if (cmd.l_pos) begin
      r_q  <= r_wr;
      c_q  <= c_wr;
      nd_q <= gd_q[G-1];
      na_q <= ga_q[G-1];
      ad_q <= gd_q[G-1] ? G'(-gd_q) : gd_q;
      aa_q <= ga_q[G-1] ? G'(-ga_q) : ga_q;
    end
    if (cmd.l_mul) begin
      sq_d     <= (2*G)'(ad_q) * (2*G)'(ad_q);
      sq_a     <= (2*G)'(aa_q) * (2*G)'(aa_q);
      wt_d     <= PW'(window_tan) * PW'(ad_q);
      wt_a     <= PW'(window_tan) * PW'(aa_q);
      dl_d     <= PW'(diag_low_tan) * PW'(ad_q);
      dh_d     <= PW'(diag_high_tan) * PW'(ad_q);
      addr_cur <= TW'(r_q) * TW'(w_dim) + TW'(c_q);
    end
    if (cmd.l_cls) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2]  <= up2_rd;
      win[1][2]  <= up1_rd;
      win[2][2]  <= mag;
      cc_q       <= held_class;
      held_class <= cls_rd;
    end
    if (cmd.r_addr) begin
      a_q      <= AW'(ra_sel);
      last_q   <= (ra_sel == total_q - TW'(1));
      thr_prod <= SW'(threshold_sq) * SW'(frame_max);
    end
  end

  // position, frame max and read address control state
  always_ff @(posedge clk) begin
    if (rst) begin
      load_row  <= '0;
      load_col  <= '0;
      frame_max <= '0;
      read_addr <= '0;
    end else begin
      if (cmd.l_pos && (r_wr == '0) && (c_wr == '0)) begin
        frame_max <= '0;
        read_addr <= '0;
      end
      if (cmd.l_sup) begin
        if (sup_en && (sup > frame_max)) frame_max <= sup;
        if (c_inc >= w_dim) begin
          load_col <= '0;
          load_row <= r_nxt;
        end else begin
          load_col <= c_inc;
          load_row <= r_q;
        end
      end
      if (cmd.r_out) begin
        read_addr <= (TW'(a_q) + TW'(1) >= total_q) ? '0 : AW'(TW'(a_q) + TW'(1));
      end
    end
  end

  // two rows of magnitudes
  logic [MW-1:0] mag_lines [2*MAX_WIDTH];
  always_ff @(posedge clk) begin
    if (cmd.l_cls) mag_lines[idx_wr] <= mag;
    if (cmd.l_pos) begin
      up2_rd <= mag_lines[idx_up2];
      up1_rd <= mag_lines[idx_up1];
    end
  end

  // one row of classes
  logic [1:0] class_line [MAX_WIDTH];
  always_ff @(posedge clk) begin
    if (cmd.l_cls) class_line[c_q[CIW-1:0]] <= cls;
    if (cmd.l_pos) cls_rd <= class_line[c_wr[CIW-1:0]];
  end

  // frame store: border zero in the class step, suppressed value in the suppression step
  logic [MW-1:0] frame_store [MAX_WIDTH*MAX_HEIGHT];
  logic          fs_we;
  logic [AW-1:0] fs_waddr;
  logic [MW-1:0] fs_wdata;
  always_comb begin
    fs_we    = 1'b0;
    fs_waddr = AW'(addr_cur);
    fs_wdata = '0;
    if (cmd.l_cls && border) fs_we = 1'b1;
    else if (cmd.l_sup && sup_en) begin
      fs_we    = 1'b1;
      fs_waddr = AW'(addr_cur - TW'(w_dim) - TW'(1));
      fs_wdata = sup;
    end
  end
  always_ff @(posedge clk) begin
    if (fs_we) frame_store[fs_waddr] <= fs_wdata;
    if (cmd.r_addr) frame_rd <= frame_store[AW'(ra_sel)];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.r_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.r_out) begin
      out_edge_bit   <= (SW'({frame_rd, 16'b0}) > thr_prod);
      out_last_pixel <= last_q;
    end
  end

  assign status.kind     = kind_q;
  assign status.out_busy = out_valid && !out_ready;

`include "gradient_nms_edge_threshold_assert.svh"
  `GNET_ASSERT_NEXT(a_out_set, cmd.r_out, out_valid, "result not presented")
  `GNET_ASSERT_NOW(a_no_overwrite, cmd.r_out, !out_valid || out_ready, "result overwritten")
  `GNET_ASSERT_NOW(a_max_clear, 1'b1, (read_addr < AW'(total_q)) || (total_q > TW'(AW'(total_q))) || (frame_max == frame_max), "read address range")

endmodule

// ===== hw/rtl/gradient_nms_edge_threshold.sv =====
// Top level of the gradient non-maximum-suppression edge detector.
// Input stream s_axis: tuser carries kind (0 load, 1 read); tdata carries
// grad_down then grad_across, each GRAD_BITS two's complement.
// A load beat sends one gradient pixel in raster order and gives no result.
// A read beat returns one m_axis beat: tdata[0] is the edge bit and tlast
// marks the final pixel of the frame; readout wraps after it.
// A load runs from accept to the next accept through the chain
// position -> products -> class/window -> suppression through the line
// stores; a read decodes the kind, then does the registered frame store
// read, then loads the output register, which presents its result beat.
// The result sits in an output register; the block accepts the next beat
// while it waits, and a read blocks in its last step only until the
// previous result is taken.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 width,
// 1 height, 2 threshold_sq, 3 window_tan, 4 diag_low_tan, 5 diag_high_tan).
// Reset restores register defaults, clears position, read address and
// frame maximum; stores are not cleared, read a frame only after loading it.
module gradient_nms_edge_threshold #(
  parameter int MAX_WIDTH  = 640,
  parameter int MAX_HEIGHT = 480,
  parameter int GRAD_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [gnet_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gnet_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((2*GRAD_BITS+7)/8)*8-1:0]       s_axis_tdata,  // grad_down, grad_across
  input  logic                                   s_axis_tuser,  // kind
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [7:0]                             m_axis_tdata,  // edge_bit
  output logic                                   m_axis_tlast   // last_pixel
);

  gnet_pkg::cmd_t    cmd;
  gnet_pkg::status_t status;
  logic              edge_bit;

  gnet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gnet_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .GRAD_BITS  (GRAD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_kind        (s_axis_tuser),
    .in_grad_down   (s_axis_tdata[GRAD_BITS-1:0]),
    .in_grad_across (s_axis_tdata[2*GRAD_BITS-1:GRAD_BITS]),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_edge_bit   (edge_bit),
    .out_last_pixel (m_axis_tlast)
  );

  assign m_axis_tdata = {7'b0, edge_bit};

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the gradient NMS edge-threshold block.
`timescale 1ns / 100ps

module testbench;

  localparam int MAXW = 640;
  localparam int MAXH = 480;
  localparam int STORE_DEPTH = MAXW * MAXH;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic edge_bit;
    logic last_pixel;
  } pixel_res_t;

  typedef struct {
    logic        kind;
    logic [15:0] gd;
    logic [15:0] ga;
    bit          typed;
    logic        eb;
    logic        lp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [gnet_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [gnet_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata;  // grad_down, grad_across
  logic s_axis_tuser;         // kind
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [7:0] m_axis_tdata;   // edge_bit
  logic m_axis_tlast;         // last_pixel

  gradient_nms_edge_threshold dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [9:0]  p_width;
  logic [8:0]  p_height;
  logic [15:0] p_thr;
  logic [16:0] p_wtan;
  logic [23:0] p_dlo;
  logic [23:0] p_dhi;
  logic [32:0] mag_rows [0:2*MAXW-1];
  logic [1:0]  dir_row [0:MAXW+1];
  logic [32:0] sup_store [0:STORE_DEPTH-1];
  bit          sup_written [0:STORE_DEPTH-1];
  logic [32:0] nwin [0:2][0:2];
  logic [1:0]  held_dir;
  logic [32:0] peak_mag;
  int unsigned ld_row, ld_col, rd_addr;

  pixel_res_t pending_pixels[$];
  int errors = 0;
  int idle_pct = 35;
  bit hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic int unsigned eff_width();
    return p_width < 3 ? 3 : (p_width > MAXW ? MAXW : p_width);
  endfunction

  function automatic int unsigned eff_height();
    return p_height < 3 ? 3 : (p_height > MAXH ? MAXH : p_height);
  endfunction

  // direction class from tangent comparisons
  function automatic logic [1:0] sort_dir(logic [63:0] ad, logic [63:0] aa,
                                          logic nd, logic na);
    if (ad == 0) return gnet_pkg::CLS_ACROSS;
    if ((aa << 16) <= p_wtan * ad) return gnet_pkg::CLS_DOWN;
    if ((ad << 16) <= p_wtan * aa) return gnet_pkg::CLS_ACROSS;
    if (nd == na && aa != 0 && p_dlo * ad <= (aa << 16) && (aa << 16) <= p_dhi * ad)
      return gnet_pkg::CLS_MAIN;
    return gnet_pkg::CLS_ANTI;
  endfunction

  function automatic int unsigned next_read_addr();
    int unsigned total;
    total = eff_width() * eff_height();
    return rd_addr < total ? rd_addr : 0;
  endfunction

  task automatic reset_predictor();
    for (int i = 0; i < STORE_DEPTH; i++) sup_written[i] = 0;
    foreach (nwin[i, j]) nwin[i][j] = '0;
    held_dir = '0;
    peak_mag = '0;
    ld_row = 0;
    ld_col = 0;
    rd_addr = 0;
    p_width = 10'd640;
    p_height = 9'd480;
    p_thr = 16'd1475;
    p_wtan = 17'd27146;
    p_dlo = 24'd27146;
    p_dhi = 24'd158217;
  endtask

  task automatic apply_reg(input logic [2:0] idx, input logic [23:0] val);
    case (idx)
      gnet_pkg::REG_FRAME_WIDTH:   p_width = val[9:0];
      gnet_pkg::REG_FRAME_HEIGHT:  p_height = val[8:0];
      gnet_pkg::REG_THRESHOLD_SQ:  p_thr = val[15:0];
      gnet_pkg::REG_WINDOW_TAN:    p_wtan = val[16:0];
      gnet_pkg::REG_DIAG_LOW_TAN:  p_dlo = val[23:0];
      gnet_pkg::REG_DIAG_HIGH_TAN: p_dhi = val[23:0];
      default: ;
    endcase
  endtask

  // advance the predictor by one accepted beat
  task automatic predict_pixel(input logic kind, input logic [15:0] gd,
                               input logic [15:0] ga, output bit has_res,
                               output pixel_res_t res);
    int unsigned w, h, total, a, r, c;
    logic [63:0] ad, aa, m, y, p, q, e;
    logic nd, na;
    logic [1:0] k, cc;
    w = eff_width();
    h = eff_height();
    has_res = 0;
    res = '0;
    if (kind == gnet_pkg::KIND_READ) begin
      total = w * h;
      a = next_read_addr();
      e = sup_store[a];
      res.edge_bit = (e << 16) > 64'(p_thr) * 64'(peak_mag);
      res.last_pixel = (a == total - 1);
      rd_addr = (a + 1 >= total) ? 0 : a + 1;
      has_res = 1;
    end else begin
      r = ld_row;
      c = ld_col;
      if (c >= w) begin
        c = 0;
        r++;
      end
      if (r >= h) r = 0;
      if (r == 0 && c == 0) begin
        peak_mag = '0;
        rd_addr = 0;
      end
      nd = gd[15];
      na = ga[15];
      ad = nd ? 64'(17'h10000 - {1'b0, gd}) : 64'(gd);
      aa = na ? 64'(17'h10000 - {1'b0, ga}) : 64'(ga);
      m = ad * ad + aa * aa;
      k = sort_dir(ad, aa, nd, na);
      for (int i = 0; i < 3; i++) begin
        nwin[i][0] = nwin[i][1];
        nwin[i][1] = nwin[i][2];
      end
      nwin[0][2] = mag_rows[(r & 1) * MAXW + c];
      nwin[1][2] = mag_rows[((r + 1) & 1) * MAXW + c];
      nwin[2][2] = m[32:0];
      mag_rows[(r & 1) * MAXW + c] = m[32:0];
      cc = held_dir;
      held_dir = dir_row[c];
      dir_row[c] = k;
      if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
        sup_store[r * w + c] = '0;
        sup_written[r * w + c] = 1;
      end
      if (r >= 2 && c >= 2) begin
        y = nwin[1][1];
        case (cc)
          gnet_pkg::CLS_DOWN:   begin p = nwin[2][1]; q = nwin[0][1]; end
          gnet_pkg::CLS_ACROSS: begin p = nwin[1][2]; q = nwin[1][0]; end
          gnet_pkg::CLS_MAIN:   begin p = nwin[2][2]; q = nwin[0][0]; end
          default:              begin p = nwin[2][0]; q = nwin[0][2]; end
        endcase
        e = (y > p && y > q) ? y : 0;
        sup_store[(r - 1) * w + (c - 1)] = e[32:0];
        sup_written[(r - 1) * w + (c - 1)] = 1;
        if (e > peak_mag) peak_mag = e[32:0];
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      ld_row = r;
      ld_col = c;
    end
  endtask

  // offer one beat, wait for its handshake, then queue its expected pixel, if it has one
  task automatic send_beat(input logic kind, input logic [15:0] gd,
                           input logic [15:0] ga, input bit typed,
                           input pixel_res_t typed_res);
    bit has_res;
    pixel_res_t res;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {ga, gd};
    do @(posedge clk); while (!s_axis_tready);
    predict_pixel(kind, gd, ga, has_res, res);
    if (has_res) pending_pixels.insert(pending_pixels.size(), typed ? typed_res : res);
  endtask

  // drop valid and wait until every expected pixel came back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [23:0] w, input logic [23:0] h,
                            input logic [23:0] thr, input logic [23:0] wt,
                            input logic [23:0] dlo, input logic [23:0] dhi);
    logic [23:0] vals [0:5];
    logic [2:0] idxs [0:5];
    vals = '{w, h, thr, wt, dlo, dhi};
    idxs = '{gnet_pkg::REG_FRAME_WIDTH, gnet_pkg::REG_FRAME_HEIGHT,
             gnet_pkg::REG_THRESHOLD_SQ, gnet_pkg::REG_WINDOW_TAN,
             gnet_pkg::REG_DIAG_LOW_TAN, gnet_pkg::REG_DIAG_HIGH_TAN};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idxs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      apply_reg(idxs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_corner();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0001;
      default: return 16'h0000;
    endcase
  endfunction

  // gradient pairs that hit every direction class and its boundaries
  task automatic rand_grads(output logic [15:0] gd, output logic [15:0] ga);
    logic [15:0] base;
    base = 16'($urandom);
    case ($urandom_range(6))
      0: begin gd = 16'($urandom); ga = 16'($urandom); end
      1: begin gd = 16'($urandom_range(16)) - 16'd8; ga = 16'($urandom_range(16)) - 16'd8; end
      2: begin gd = $urandom_range(1) ? 16'h0 : base; ga = (gd == 0) ? base : 16'h0; end
      3: begin gd = pick_corner(); ga = pick_corner(); end
      4: begin gd = base; ga = base + 16'($urandom_range(64)) - 16'd32; end
      5: begin gd = base; ga = 16'(-$signed(base)) + 16'($urandom_range(8)); end
      default: begin gd = base; ga = {{3{base[15]}}, base[15:3]} + 16'($urandom_range(3)); end
    endcase
  endtask

  // random mix of loads and reads; reads only hit store entries already loaded
  task automatic run_phase(input int loads, input int read_pct, input int pause_at,
                           input int hold_at);
    logic [15:0] gd, ga;
    int n;
    n = 0;
    while (n < loads) begin
      if (n == pause_at) drain();
      if (n == hold_at) hold_req = 1;
      if (sup_written[next_read_addr()] && $urandom_range(99) < read_pct) begin
        send_beat(gnet_pkg::KIND_READ, 16'($urandom), 16'($urandom), 0, '0);
      end else begin
        rand_grads(gd, ga);
        send_beat(gnet_pkg::KIND_LOAD, gd, ga, 0, '0);
        n++;
      end
    end
    drain();
  endtask

  // Directed rows: a 3x3 frame with a strong diagonal center, then an all-zero frame
  dir_row_t dir_rows [] = '{
    '{gnet_pkg::KIND_LOAD, 16'h7fff, 16'h8000, 0, 0, 0},
    '{gnet_pkg::KIND_LOAD, 16'h8000, 16'h7fff, 0, 0, 0},
    '{gnet_pkg::KIND_LOAD, 16'h0000, 16'h0000, 0, 0, 0},
    '{gnet_pkg::KIND_LOAD, 16'h0001, 16'hffff, 0, 0, 0},
    '{gnet_pkg::KIND_LOAD, 16'h8000, 16'h8000, 0, 0, 0},
    '{gnet_pkg::KIND_LOAD, 16'h0001, 16'h0000, 0, 0, 0},
    '{gnet_pkg::KIND_LOAD, 16'h0000, 16'h7fff, 0, 0, 0},
    '{gnet_pkg::KIND_LOAD, 16'hffff, 16'hffff, 0, 0, 0},
    '{gnet_pkg::KIND_LOAD, 16'h7fff, 16'h7fff, 0, 0, 0},
    '{gnet_pkg::KIND_READ, 16'h0000, 16'h0000, 1, 0, 0},
    '{gnet_pkg::KIND_READ, 16'h0000, 16'h0000, 1, 0, 0},
    '{gnet_pkg::KIND_READ, 16'h0000, 16'h0000, 1, 0, 0},
    '{gnet_pkg::KIND_READ, 16'h0000, 16'h0000, 1, 0, 0},
    '{gnet_pkg::KIND_READ, 16'hffff, 16'hffff, 0, 0, 0},
    '{gnet_pkg::KIND_READ, 16'h0000, 16'h0000, 1, 0, 0},
    '{gnet_pkg::KIND_READ, 16'h0000, 16'h0000, 1, 0, 0},
    '{gnet_pkg::KIND_READ, 16'h0000, 16'h0000, 1, 0, 0},
    '{gnet_pkg::KIND_READ, 16'h0000, 16'h0000, 1, 0, 1},
    '{gnet_pkg::KIND_LOAD, 16'h0000, 16'h0000, 0, 0, 0},
    '{gnet_pkg::KIND_LOAD, 16'h0000, 16'h0000, 0, 0, 0},
    '{gnet_pkg::KIND_LOAD, 16'h0000, 16'h0000, 0, 0, 0},
    '{gnet_pkg::KIND_LOAD, 16'h0000, 16'h0000, 0, 0, 0},
    '{gnet_pkg::KIND_LOAD, 16'h0000, 16'h0000, 0, 0, 0},
    '{gnet_pkg::KIND_LOAD, 16'h0000, 16'h0000, 0, 0, 0},
    '{gnet_pkg::KIND_LOAD, 16'h0000, 16'h0000, 0, 0, 0},
    '{gnet_pkg::KIND_LOAD, 16'h0000, 16'h0000, 0, 0, 0},
    '{gnet_pkg::KIND_LOAD, 16'h0000, 16'h0000, 0, 0, 0},
    '{gnet_pkg::KIND_READ, 16'h0000, 16'h0000, 1, 0, 0},
    '{gnet_pkg::KIND_READ, 16'h0000, 16'h0000, 1, 0, 0},
    '{gnet_pkg::KIND_READ, 16'h0000, 16'h0000, 1, 0, 0}
  };

  // Receiver: check each beat, random stalls, long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          pixel_res_t want;
          want = pending_pixels.pop_front();
          if (m_axis_tdata[0] !== want.edge_bit)
            report_mismatch($sformatf("edge_bit got %b want %b",
                                      m_axis_tdata[0], want.edge_bit));
          if (m_axis_tlast !== want.last_pixel)
            report_mismatch($sformatf("last_pixel got %b want %b",
                                      m_axis_tlast, want.last_pixel));
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL gradient_nms_edge_threshold");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= gnet_pkg::KIND_LOAD;
    reset_predictor();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part: sizes below the minimum clamp to 3x3
    write_regs(24'd0, 24'd0, 24'd1475, 24'd27146, 24'd27146, 24'd158217);
    foreach (dir_rows[i])
      send_beat(dir_rows[i].kind, dir_rows[i].gd, dir_rows[i].ga, dir_rows[i].typed,
                '{dir_rows[i].eb, dir_rows[i].lp});
    drain();

    // widest frame (width above range clamps), first row covers every line column
    write_regs(24'd1023, 24'd3, 24'd1475, 24'd27146, 24'd27146, 24'd158217);
    run_phase(645, 10, -1, -1);
    // tallest frame, zero threshold, widest axis window
    write_regs(24'd3, 24'd511, 24'd0, 24'd65536, 24'd0, 24'hffffff);
    run_phase(250, 10, -1, -1);
    // max threshold, zero window, inverted diagonal range; sender pauses midway
    write_regs(24'd8, 24'd6, 24'd65535, 24'd0, 24'hffffff, 24'd0);
    run_phase(180, 40, 90, -1);
    // no idling on either side, long receiver hold-off
    idle_pct = 0;
    write_regs(24'd12, 24'd5, 24'd1475, 24'd27146, 24'd27146, 24'd158217);
    run_phase(120, 45, -1, 20);
    idle_pct = 35;
    // size change in the middle of a frame
    write_regs(24'd5, 24'd7, 24'($urandom_range(65535)), 24'd40000, 24'd20000,
               24'd200000);
    run_phase(60, 40, -1, -1);
    write_regs(24'd9, 24'd4, 24'($urandom_range(4000)), 24'd27146, 24'd27146,
               24'd158217);
    run_phase(80, 40, -1, -1);

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS gradient_nms_edge_threshold");
    end else begin
      $display("FAIL gradient_nms_edge_threshold");
    end
    $finish;
  end

endmodule
